>>> src/rq_pkg.sv
// Shared types and constants for the retransmit queue.
package rq_pkg;

  // Number of cells in the entry chain.
  localparam int QUEUE_DEPTH = 16;
  // Width of the fill count and pass counters (holds 0..QUEUE_DEPTH).
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int HANDLE_W = 16;
  localparam int ID_W     = 16;
  localparam int TIME_W   = 32;
  localparam int SENDS_W  = 8;

  localparam logic [SENDS_W-1:0] SENDS_MAX = {SENDS_W{1'b1}};

  // Register indexes of the configuration port.
  typedef enum logic [0:0] {
    REG_RETRY_INTERVAL = 1'b0,
    REG_SEND_LIMIT     = 1'b1
  } reg_idx_t;

  // Request commands.
  typedef enum logic [1:0] {
    CMD_ADD     = 2'd0,
    CMD_SERVICE = 2'd1,
    CMD_ACK     = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  // Result codes.
  typedef enum logic [2:0] {
    CODE_SEND      = 3'd0,
    CODE_RELEASED  = 3'd1,
    CODE_ADDED     = 3'd2,
    CODE_FULL      = 3'd3,
    CODE_NOT_FOUND = 3'd4,
    CODE_PASS_DONE = 3'd5
  } code_t;

  // Control sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SERVICE,
    ST_ACK
  } state_t;

  // One stored message.
  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic                checked;
    logic [ID_W-1:0]     id;
    logic [TIME_W-1:0]   stamp;
    logic [SENDS_W-1:0]  sends;
  } entry_t;

  // Per-cell controls: load the shared entry, or take the right neighbor.
  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

endpackage

>>> src/retransmit_queue_core.sv
// Retransmit queue top level: cell chain, pass sequencer and result register.
//
// Entries live in a chain of cells with the oldest entry in cell 0. A service
// pass or an acknowledge rotates the chain one entry per cycle past the head
// cell, where the entry is examined and either written back at the tail,
// restamped in place, or dropped; in a service pass an entry that is sent and
// released in the same pass is first restamped in place, then released. A
// single result register sits on the output; while it is held by rsp_stall
// the pass waits. A new request is taken only when the previous one has
// finished.
module retransmit_queue_core (
  input  logic                   clk,
  input  logic                   rst,
  // configuration
  input  logic                   cfg_we,
  input  logic [0:0]             cfg_index,
  input  logic [31:0]            cfg_data,
  // request channel
  input  logic                   req_valid,
  output logic                   req_stall,
  input  logic [1:0]             cmd,
  input  logic [15:0]            msg_handle,
  input  logic                   is_checked,
  input  logic [15:0]            msg_id,
  input  logic [31:0]            now,
  // result channel
  output logic                   rsp_valid,
  input  logic                   rsp_stall,
  output logic [2:0]             code,
  output logic [15:0]            out_handle,
  output logic [15:0]            out_id,
  output logic                   last
);
  import rq_pkg::*;

  // Configuration registers
  logic [TIME_W-1:0]  retry_interval;
  logic [SENDS_W-1:0] send_limit;

  // Control state
  state_t             state, state_next;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   remaining;
  logic               found;
  logic [TIME_W-1:0]  now_r;
  logic [ID_W-1:0]    ack_id;

  // Chain
  entry_t             cells [QUEUE_DEPTH];
  cell_ctrl_t         cell_ctrl [QUEUE_DEPTH];
  entry_t             ld_entry;

  // Step controls
  logic               go;
  logic               req_fire;
  logic               emit;
  code_t              emit_code;
  logic [HANDLE_W-1:0] emit_handle;
  logic [ID_W-1:0]    emit_id;
  logic               emit_last;
  logic               do_shift, load_tail, load_head, load_add;
  logic               cnt_inc, cnt_dec, rem_dec, found_set;
  logic               start_pass;

  // Head examination
  entry_t             head;
  entry_t             head_upd;
  logic [TIME_W-1:0]  elapsed;
  logic [SENDS_W-1:0] sends_inc;
  logic               send_now;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      retry_interval <= TIME_W'(1000);
      send_limit     <= SENDS_W'(3);
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_RETRY_INTERVAL: retry_interval <= cfg_data;
        REG_SEND_LIMIT:     send_limit     <= cfg_data[SENDS_W-1:0];
        default: ;
      endcase
    end
  end

  // Result register free next cycle
  assign go        = !rsp_valid || !rsp_stall;
  assign req_stall = (state != ST_IDLE) || !go;
  assign req_fire  = req_valid && !req_stall;

  // Examine the head cell
  assign head      = cells[0];
  assign elapsed   = now_r - head.stamp;
  assign sends_inc = (head.sends == SENDS_MAX) ? head.sends : head.sends + SENDS_W'(1);
  assign send_now  = (head.sends == '0) || (elapsed > retry_interval);

  always_comb begin
    head_upd = head;
    if (send_now) begin
      head_upd.stamp = now_r;
      head_upd.sends = sends_inc;
    end
  end

  // Next state and step controls
  always_comb begin
    state_next  = state;
    emit        = 1'b0;
    emit_code   = CODE_SEND;
    emit_handle = head.handle;
    emit_id     = head.id;
    emit_last   = 1'b0;
    do_shift    = 1'b0;
    load_tail   = 1'b0;
    load_head   = 1'b0;
    load_add    = 1'b0;
    cnt_inc     = 1'b0;
    cnt_dec     = 1'b0;
    rem_dec     = 1'b0;
    found_set   = 1'b0;
    start_pass  = 1'b0;
    ld_entry    = head_upd;

    unique case (state)
      ST_IDLE: begin
        ld_entry.handle  = msg_handle;
        ld_entry.checked = is_checked;
        ld_entry.id      = msg_id;
        ld_entry.stamp   = now;
        ld_entry.sends   = '0;
        if (req_fire) begin
          case (cmd_t'(cmd))
            CMD_ADD: begin
              emit        = 1'b1;
              emit_handle = msg_handle;
              emit_id     = msg_id;
              emit_last   = 1'b1;
              if (count == CNT_W'(QUEUE_DEPTH)) begin
                emit_code = CODE_FULL;
              end else begin
                emit_code = CODE_ADDED;
                load_add  = 1'b1;
                cnt_inc   = 1'b1;
              end
            end
            CMD_SERVICE: begin
              start_pass = 1'b1;
              state_next = ST_SERVICE;
            end
            CMD_ACK: begin
              start_pass = 1'b1;
              state_next = ST_ACK;
            end
            default: ;
          endcase
        end
      end

      ST_SERVICE: begin
        if (go) begin
          if (remaining == '0) begin
            // close the pass
            emit        = 1'b1;
            emit_code   = CODE_PASS_DONE;
            emit_handle = '0;
            emit_id     = '0;
            emit_last   = 1'b1;
            state_next  = ST_IDLE;
          end else if (!head.checked) begin
            // send once and drop
            emit     = 1'b1;
            do_shift = 1'b1;
            cnt_dec  = 1'b1;
            rem_dec  = 1'b1;
          end else if (send_now) begin
            emit = 1'b1;
            if (sends_inc > send_limit) begin
              // restamp in place; the release follows on the next step
              load_head = 1'b1;
            end else begin
              do_shift  = 1'b1;
              load_tail = 1'b1;
              rem_dec   = 1'b1;
            end
          end else if (head.sends > send_limit) begin
            // over the limit: release and drop
            emit      = 1'b1;
            emit_code = CODE_RELEASED;
            do_shift  = 1'b1;
            cnt_dec   = 1'b1;
            rem_dec   = 1'b1;
          end else begin
            // keep unchanged, rotate to the tail
            do_shift  = 1'b1;
            load_tail = 1'b1;
            rem_dec   = 1'b1;
          end
        end
      end

      ST_ACK: begin
        ld_entry = head;
        if (go) begin
          if (remaining == '0) begin
            state_next = ST_IDLE;
            if (!found) begin
              emit        = 1'b1;
              emit_code   = CODE_NOT_FOUND;
              emit_handle = '0;
              emit_id     = ack_id;
              emit_last   = 1'b1;
            end
          end else if (!found && (head.id == ack_id)) begin
            // first match: release and drop
            emit      = 1'b1;
            emit_code = CODE_RELEASED;
            emit_last = 1'b1;
            found_set = 1'b1;
            do_shift  = 1'b1;
            cnt_dec   = 1'b1;
            rem_dec   = 1'b1;
          end else begin
            do_shift  = 1'b1;
            load_tail = 1'b1;
            rem_dec   = 1'b1;
          end
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  // Per-cell controls and the chain itself
  for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
    assign cell_ctrl[k].shift = do_shift;
    assign cell_ctrl[k].load  = (load_tail && (count == CNT_W'(k + 1))) ||
                                (load_head && (k == 0)) ||
                                (load_add && (count == CNT_W'(k)));
    if (k == QUEUE_DEPTH - 1) begin : g_end
      rq_cell u_cell (
        .clk  (clk),
        .ctrl (cell_ctrl[k]),
        .nb   (ld_entry),
        .ld   (ld_entry),
        .q    (cells[k])
      );
    end else begin : g_mid
      rq_cell u_cell (
        .clk  (clk),
        .ctrl (cell_ctrl[k]),
        .nb   (cells[k + 1]),
        .ld   (ld_entry),
        .q    (cells[k])
      );
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Counters and pass context
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      remaining <= '0;
      found     <= 1'b0;
    end else begin
      if (cnt_inc) begin
        count <= count + CNT_W'(1);
      end else if (cnt_dec) begin
        count <= count - CNT_W'(1);
      end
      if (start_pass) begin
        remaining <= count;
        found     <= 1'b0;
      end else begin
        if (rem_dec) begin
          remaining <= remaining - CNT_W'(1);
        end
        if (found_set) begin
          found <= 1'b1;
        end
      end
    end
  end

  // Latch request operands for the pass
  always_ff @(posedge clk) begin
    if (start_pass) begin
      now_r  <= now;
      ack_id <= msg_id;
    end
  end

  // Result register: hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (emit) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      code       <= emit_code;
      out_handle <= emit_handle;
      out_id     <= emit_id;
      last       <= emit_last;
    end
  end

  // Checks
  assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count above queue depth");

  assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> (remaining <= count))
    else $error("pass counter exceeds stored entries");

  assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> req_stall)
    else $error("request taken during a pass");

  assert property (@(posedge clk) disable iff (rst)
    !go |=> $stable(count))
    else $error("entry count moved while result register blocked");

endmodule

>>> src/rq_cell.sv
// One cell of the entry chain: holds an entry, takes its neighbor or a load.
module rq_cell (
  input  logic              clk,
  input  rq_pkg::cell_ctrl_t ctrl,
  input  rq_pkg::entry_t    nb,
  input  rq_pkg::entry_t    ld,
  output rq_pkg::entry_t    q
);
  import rq_pkg::*;

  // Load has priority over the shift from the neighbor
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      q <= ld;
    end else if (ctrl.shift) begin
      q <= nb;
    end
  end

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the retransmit queue core: shadow table, stimulus and checks.
module tb;
  import rq_pkg::*;

  localparam int CYCLE_LIMIT   = 500000;
  localparam int SETTLE_CYCLES = 2 * QUEUE_DEPTH + 8;
  localparam int HOLD_CYCLES   = 400;

  typedef struct {
    code_t       code;
    logic [15:0] handle;
    logic [15:0] id;
    logic        last;
  } rq_result_t;

  // Shadow copy of the message table; predicts and checks the result stream.
  class retx_shadow;
    logic [15:0] slot_handle [QUEUE_DEPTH];
    logic        slot_checked[QUEUE_DEPTH];
    logic [15:0] slot_id     [QUEUE_DEPTH];
    logic [31:0] slot_stamp  [QUEUE_DEPTH];
    logic [7:0]  slot_sends  [QUEUE_DEPTH];
    int          fill;
    logic [31:0] retry_interval;
    logic [7:0]  send_limit;
    rq_result_t  batch[$];
    rq_result_t  due_results[$];
    int          requests;
    int          results_checked;
    int          errors;

    function new();
      fill            = 0;
      retry_interval  = 32'd1000;
      send_limit      = 8'd3;
      requests        = 0;
      results_checked = 0;
      errors          = 0;
    endfunction

    function void set_registers(logic [31:0] interval, logic [7:0] limit);
      retry_interval = interval;
      send_limit     = limit;
    endfunction

    function void add_result(code_t c, logic [15:0] h, logic [15:0] i);
      rq_result_t r;
      r.code   = c;
      r.handle = h;
      r.id     = i;
      r.last   = 1'b0;
      batch.push_back(r);
    endfunction

    // Remove one slot and close the gap, keeping order.
    function void drop_at(int pos);
      for (int k = pos; k < fill - 1; k++) begin
        slot_handle[k]  = slot_handle[k + 1];
        slot_checked[k] = slot_checked[k + 1];
        slot_id[k]      = slot_id[k + 1];
        slot_stamp[k]   = slot_stamp[k + 1];
        slot_sends[k]   = slot_sends[k + 1];
      end
      fill--;
    endfunction

    // Apply one accepted request and queue the results it should produce.
    function void note_request(cmd_t op, logic [15:0] h, logic chk, logic [15:0] id,
                               logic [31:0] t);
      int i;
      bit found;
      logic [31:0] age;
      requests++;
      batch.delete();
      case (op)
        CMD_ADD: begin
          if (fill >= QUEUE_DEPTH) begin
            add_result(CODE_FULL, h, id);
          end else begin
            slot_handle[fill]  = h;
            slot_checked[fill] = chk;
            slot_id[fill]      = id;
            slot_stamp[fill]   = t;
            slot_sends[fill]   = 8'd0;
            fill++;
            add_result(CODE_ADDED, h, id);
          end
        end
        CMD_SERVICE: begin
          i = 0;
          while (i < fill) begin
            if (!slot_checked[i]) begin
              add_result(CODE_SEND, slot_handle[i], slot_id[i]);
              drop_at(i);
            end else begin
              age = t - slot_stamp[i];
              if (slot_sends[i] == 8'd0 || age > retry_interval) begin
                add_result(CODE_SEND, slot_handle[i], slot_id[i]);
                slot_stamp[i] = t;
                if (slot_sends[i] != SENDS_MAX) slot_sends[i]++;
              end
              if (slot_sends[i] > send_limit) begin
                add_result(CODE_RELEASED, slot_handle[i], slot_id[i]);
                drop_at(i);
              end else begin
                i++;
              end
            end
          end
          add_result(CODE_PASS_DONE, 16'd0, 16'd0);
        end
        CMD_ACK: begin
          found = 1'b0;
          for (i = 0; i < fill && !found; i++) begin
            if (slot_id[i] == id) begin
              add_result(CODE_RELEASED, slot_handle[i], slot_id[i]);
              drop_at(i);
              found = 1'b1;
            end
          end
          if (!found) add_result(CODE_NOT_FOUND, 16'd0, id);
        end
        default: return;
      endcase
      batch[batch.size() - 1].last = 1'b1;
      foreach (batch[k]) due_results.push_back(batch[k]);
    endfunction

    // Compare one accepted result with the oldest prediction.
    function void check_result(logic [2:0] c, logic [15:0] h, logic [15:0] i, logic l);
      rq_result_t want;
      if (due_results.size() == 0) begin
        $error("unexpected result: code %0d handle %h id %h last %b", c, h, i, l);
        errors++;
        return;
      end
      want = due_results.pop_front();
      results_checked++;
      if (c !== want.code) begin
        $error("code: expected %0d, got %0d", want.code, c);
        errors++;
      end
      if (h !== want.handle) begin
        $error("out_handle: expected %h, got %h", want.handle, h);
        errors++;
      end
      if (i !== want.id) begin
        $error("out_id: expected %h, got %h", want.id, i);
        errors++;
      end
      if (l !== want.last) begin
        $error("last: expected %b, got %b", want.last, l);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        req_valid;
  logic        req_stall;
  logic [1:0]  cmd;
  logic [15:0] msg_handle;
  logic        is_checked;
  logic [15:0] msg_id;
  logic [31:0] now;
  logic        rsp_valid;
  logic        rsp_stall;
  logic [2:0]  code;
  logic [15:0] out_handle;
  logic [15:0] out_id;
  logic        last;

  retx_shadow  shadow = new();
  logic [31:0] wall_clock = 32'd0;
  bit          no_idle = 1'b0;
  bit          hold_start = 1'b0;
  int          settings_used = 0;
  int          cycle_count = 0;

  retransmit_queue_core DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .cmd        (cmd),
    .msg_handle (msg_handle),
    .is_checked (is_checked),
    .msg_id     (msg_id),
    .now        (now),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .code       (code),
    .out_handle (out_handle),
    .out_id     (out_id),
    .last       (last)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // End the run if it hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Drive the result stall: random idling, or a long hold when asked.
  initial begin : result_side
    int hold_left;
    hold_left = 0;
    rsp_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_start) begin
        hold_left  = HOLD_CYCLES;
        hold_start = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= !no_idle && ($urandom_range(99) < 19);
      end
    end
  end

  // Check every accepted result.
  always @(posedge clk) begin
    if (!rst && rsp_valid === 1'b1 && rsp_stall === 1'b0)
      shadow.check_result(code, out_handle, out_id, last);
  end

  // Offer one request, idling first at random, and hold it until accepted.
  task automatic offer_request(cmd_t op, logic [15:0] h, logic chk, logic [15:0] id,
                               logic [31:0] t);
    if (!no_idle) begin
      while ($urandom_range(99) < 19) begin
        req_valid <= 1'b0;
        @(posedge clk);
      end
    end
    req_valid  <= 1'b1;
    cmd        <= op;
    msg_handle <= h;
    is_checked <= chk;
    msg_id     <= id;
    now        <= t;
    @(posedge clk);
    while (req_stall !== 1'b0) @(posedge clk);
    shadow.note_request(op, h, chk, id, t);
  endtask

  // Drop the request line and wait until every predicted result has arrived.
  task automatic wait_for_results();
    req_valid <= 1'b0;
    @(posedge clk);
    while (shadow.due_results.size() != 0) @(posedge clk);
  endtask

  // Write both registers once the block has gone quiet.
  task automatic apply_settings(logic [31:0] interval, logic [7:0] limit);
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_RETRY_INTERVAL;
    cfg_data  <= interval;
    @(posedge clk);
    cfg_index <= REG_SEND_LIMIT;
    cfg_data  <= {24'd0, limit};
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow.set_registers(interval, limit);
    settings_used++;
  endtask

  // Pick one random request: mostly well-formed traffic on a small id pool, some noise.
  task automatic random_request(int id_pool, int add_pct, int checked_pct, int step_max,
                                output bit counted);
    int pick;
    logic [15:0] rid;
    pick    = $urandom_range(99);
    rid     = 16'($urandom_range(id_pool - 1));
    counted = 1'b1;
    if (pick < 3) begin
      counted = 1'b0;
      offer_request(CMD_NONE, 16'($urandom), 1'($urandom_range(1)), 16'($urandom),
                    $urandom);
    end else if (pick < 9) begin
      offer_request(cmd_t'($urandom_range(2)), 16'($urandom), 1'($urandom_range(1)),
                    16'($urandom), $urandom);
    end else if (pick < 9 + add_pct) begin
      offer_request(CMD_ADD, 16'($urandom), $urandom_range(99) < checked_pct, rid,
                    wall_clock);
    end else if ($urandom_range(99) < 60) begin
      wall_clock += $urandom_range(step_max);
      offer_request(CMD_SERVICE, 16'($urandom), 1'($urandom_range(1)), 16'($urandom),
                    wall_clock);
    end else begin
      offer_request(CMD_ACK, 16'($urandom), 1'($urandom_range(1)), rid, wall_clock);
    end
  endtask

  task automatic random_phase(int items, int id_pool, int add_pct, int checked_pct,
                              int step_max, int hold_at, int pause_at);
    int done;
    bit counted;
    done = 0;
    while (done < items) begin
      if (done == hold_at) begin
        hold_start = 1'b1;
        hold_at    = -1;
      end
      if (done == pause_at) begin
        wait_for_results();
        pause_at = -1;
      end
      random_request(id_pool, add_pct, checked_pct, step_max, counted);
      if (counted) done++;
    end
  endtask

  initial begin : stimulus
    rst        = 1'b1;
    cfg_we     = 1'b0;
    cfg_index  = REG_RETRY_INTERVAL;
    cfg_data   = 32'd0;
    req_valid  = 1'b0;
    cmd        = CMD_ADD;
    msg_handle = 16'd0;
    is_checked = 1'b0;
    msg_id     = 16'd0;
    now        = 32'd0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty table, idle command, field extremes, interval boundary, retry limit.
    offer_request(CMD_ACK, 16'h0000, 1'b0, 16'hFFFF, 32'h0);
    offer_request(CMD_SERVICE, 16'h0000, 1'b0, 16'h0000, 32'h0);
    offer_request(CMD_NONE, 16'hFFFF, 1'b1, 16'hFFFF, 32'hFFFF_FFFF);
    offer_request(CMD_ADD, 16'hFFFF, 1'b0, 16'h0000, 32'h0);
    offer_request(CMD_ADD, 16'h0000, 1'b1, 16'hFFFF, 32'hFFFF_FFFF);
    offer_request(CMD_ADD, 16'h1234, 1'b1, 16'h0005, 32'h0);
    offer_request(CMD_ADD, 16'h00AA, 1'b0, 16'h0005, 32'h0);
    offer_request(CMD_SERVICE, 16'h0000, 1'b0, 16'h0000, 32'hFFFF_FFF0);
    offer_request(CMD_SERVICE, 16'h0000, 1'b0, 16'h0000, 32'h0000_0100);
    offer_request(CMD_SERVICE, 16'h0000, 1'b0, 16'h0000, 32'h0000_03D8);
    offer_request(CMD_SERVICE, 16'h0000, 1'b0, 16'h0000, 32'h0000_03D9);
    offer_request(CMD_ACK, 16'h0000, 1'b0, 16'h0005, 32'h0);
    offer_request(CMD_ACK, 16'h0000, 1'b0, 16'h0005, 32'h0);
    offer_request(CMD_SERVICE, 16'h0000, 1'b0, 16'h0000, 32'h0000_0800);
    offer_request(CMD_SERVICE, 16'h0000, 1'b0, 16'h0000, 32'h0000_0C00);

    // Saturate the send count with no limit, then drop the limit to its ceiling.
    apply_settings(32'd0, 8'd255);
    wall_clock = $urandom;
    offer_request(CMD_ADD, 16'($urandom), 1'b1, 16'h0101, wall_clock);
    offer_request(CMD_ADD, 16'($urandom), 1'b1, 16'h0202, wall_clock);
    repeat (258) begin
      wall_clock += $urandom_range(1, 1000);
      offer_request(CMD_SERVICE, 16'h0000, 1'b0, 16'h0000, wall_clock);
    end
    apply_settings(32'd0, 8'd254);
    wall_clock += 32'd1;
    offer_request(CMD_SERVICE, 16'h0000, 1'b0, 16'h0000, wall_clock);

    // Lowest settings, both sides running flat out.
    apply_settings(32'd0, 8'd0);
    no_idle = 1'b1;
    random_phase(20, 8, 40, 60, 3, -1, -1);
    no_idle = 1'b0;

    // Highest settings: entries linger, so the table fills and adds get dropped.
    apply_settings(32'hFFFF_FFFF, 8'd254);
    random_phase(30, 16, 75, 90, 5000, -1, 15);

    // Moderate settings across the time wrap, with a long receiver hold.
    apply_settings(32'd100, 8'd3);
    wall_clock = 32'hFFFF_FF00;
    random_phase(20, 8, 40, 70, 250, 8, -1);

    // Random settings.
    begin : last_phase
      int interval;
      interval = $urandom_range(1, 5000);
      apply_settings(interval, 8'($urandom_range(1, 8)));
      random_phase(20, 12, 40, 70, 2 * interval, -1, 10);
    end

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Covered %0d requests (add, service, acknowledge, idle) and %0d results",
             shadow.requests, shadow.results_checked);
    $display("across %0d register settings, including a full table and count saturation.",
             settings_used);
    if (shadow.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/rq_pkg.sv
src/rq_cell.sv
src/retransmit_queue_core.sv
tb/tb.sv
